// ===== hdl/gdjs_pkg.sv =====
// ----------------------------------------------------------------------------
// gdjs_pkg
// Shared sizes, item types and controller/datapath interface structs for the
// greedy deadline job scheduler.
// ----------------------------------------------------------------------------
package gdjs_pkg;

  // storage sizes
  localparam int MaxJobs  = 64;
  localparam int MaxSlots = 32;

  // derived widths
  localparam int JobAw  = (MaxJobs > 1) ? $clog2(MaxJobs) : 1;
  localparam int JobCw  = $clog2(MaxJobs + 1);
  localparam int SlotW  = $clog2(MaxSlots + 1);
  localparam int SlotAw = (MaxSlots > 1) ? $clog2(MaxSlots) : 1;

  // fixed field widths
  localparam int NameW    = 16;
  localparam int DlW      = 6;
  localparam int ProfitW  = 16;
  localparam int SlotNumW = 6;
  localparam int TotalW   = 21;

  // input item
  typedef struct packed {
    logic [NameW-1:0]   job_name;
    logic [DlW-1:0]     job_deadline;
    logic [ProfitW-1:0] job_profit;
    logic               last_job;
  } gdjs_in_t;

  // result item
  typedef struct packed {
    logic [SlotNumW-1:0] slot_number;
    logic                slot_filled;
    logic [NameW-1:0]    placed_name;
    logic [ProfitW-1:0]  placed_profit;
    logic [TotalW-1:0]   total_profit;
    logic                last_slot;
  } gdjs_out_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;        // store the accepted job
    logic sched_init;  // clear slots and round state
    logic scan_rd;     // read job at scan index, advance scan
    logic place_init;  // start slot search at min(deadline, horizon)
    logic place_step;  // claim the slot or move one slot down
    logic round_next;  // retire the selected job, restart scan
    logic out_init;    // first slot, total cleared
    logic out_rd;      // read the job held by the current slot
    logic out_ld;      // load the result register
    logic out_next;    // result taken, advance slot
    logic finish;      // empty the job store, clear the horizon
  } gdjs_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic hz_zero;
    logic scan_last;
    logic k_done;
    logic rounds_last;
    logic sched_full;
    logic slot_last;
    logic out_taken;
  } gdjs_sts_t;

endpackage

// ===== hdl/gdjs_dp.sv =====
// ----------------------------------------------------------------------------
// gdjs_dp
// Datapath: job memory, max-profit selection scan, slot table with downward
// free-slot search, and the result register with running profit total.
// ----------------------------------------------------------------------------
module gdjs_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  gdjs_pkg::gdjs_cmd_t cmd_i,
  output gdjs_pkg::gdjs_sts_t sts_o,
  input  gdjs_pkg::gdjs_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output gdjs_pkg::gdjs_out_t out_data_o
);

  typedef struct packed {
    logic [gdjs_pkg::NameW-1:0]   name;
    logic [gdjs_pkg::SlotW-1:0]   deadline;
    logic [gdjs_pkg::ProfitW-1:0] profit;
  } job_t;

  // job memory
  job_t mem [gdjs_pkg::MaxJobs];
  job_t rd_data_q;

  // control state
  logic [gdjs_pkg::JobCw-1:0]  cnt_q, cnt_d;
  logic [gdjs_pkg::SlotW-1:0]  hz_q, hz_d;
  logic [gdjs_pkg::JobAw-1:0]  j_q, j_d;
  logic [gdjs_pkg::JobAw-1:0]  r_q, r_d;
  logic                        cmp_vld_q;
  logic [gdjs_pkg::JobAw-1:0]  cmp_idx_q;
  logic                        last_vld_q, last_vld_d;
  logic                        best_found_q, best_found_d;
  logic [gdjs_pkg::SlotW-1:0]  k_q, k_d;
  logic [gdjs_pkg::MaxSlots-1:0] slot_vld_q, slot_vld_d;
  logic [gdjs_pkg::SlotW-1:0]  filled_q, filled_d;
  logic [gdjs_pkg::SlotW-1:0]  i_q, i_d;
  logic [gdjs_pkg::TotalW-1:0] total_q, total_d;
  logic                        out_vld_q, out_vld_d;

  // payload state
  logic [gdjs_pkg::JobAw-1:0]   best_idx_q;
  logic [gdjs_pkg::ProfitW-1:0] best_profit_q;
  logic [gdjs_pkg::SlotW-1:0]   best_dl_q;
  logic [gdjs_pkg::JobAw-1:0]   last_idx_q;
  logic [gdjs_pkg::ProfitW-1:0] last_profit_q;
  logic [gdjs_pkg::JobAw-1:0]   slot_idx_q [gdjs_pkg::MaxSlots];
  gdjs_pkg::gdjs_out_t          out_q;

  logic                        store_ok;
  logic [gdjs_pkg::SlotW-1:0]  sat_dl;
  logic                        cand_ok;
  logic                        cand_better;
  logic                        out_phase;
  logic [gdjs_pkg::SlotAw-1:0] slot_addr;
  logic                        k_free;
  logic [gdjs_pkg::JobAw-1:0]  rd_addr;
  logic [gdjs_pkg::ProfitW-1:0] ld_profit;
  logic [gdjs_pkg::NameW-1:0]  ld_name;

  // deadline saturation
  always_comb begin
    if (32'(in_data_i.job_deadline) > 32'(gdjs_pkg::MaxSlots)) begin
      sat_dl = gdjs_pkg::SlotW'(gdjs_pkg::MaxSlots);
    end else begin
      sat_dl = gdjs_pkg::SlotW'(in_data_i.job_deadline);
    end
  end

  assign store_ok = cnt_q < gdjs_pkg::JobCw'(gdjs_pkg::MaxJobs);

  // candidate must come after the previous pick: lower profit, or equal
  // profit and a later arrival
  assign cand_ok = !last_vld_q || (rd_data_q.profit < last_profit_q) ||
                   ((rd_data_q.profit == last_profit_q) && (cmp_idx_q > last_idx_q));

  // candidate compare, strict so the earliest of equal profits wins
  assign cand_better = cmp_vld_q && cand_ok &&
                       (!best_found_q || (rd_data_q.profit > best_profit_q));

  // slot table address: output slot or search position
  assign out_phase = cmd_i.out_rd || cmd_i.out_ld;
  assign slot_addr = out_phase ? gdjs_pkg::SlotAw'(i_q - gdjs_pkg::SlotW'(1))
                               : gdjs_pkg::SlotAw'(k_q - gdjs_pkg::SlotW'(1));
  assign k_free    = (k_q != '0) && !slot_vld_q[slot_addr];

  assign rd_addr = cmd_i.out_rd ? slot_idx_q[slot_addr] : j_q;

  // result payload for the current slot
  assign ld_name   = slot_vld_q[slot_addr] ? rd_data_q.name : '0;
  assign ld_profit = slot_vld_q[slot_addr] ? rd_data_q.profit : '0;

  // next-state logic for control registers
  always_comb begin
    cnt_d        = cnt_q;
    hz_d         = hz_q;
    j_d          = j_q;
    r_d          = r_q;
    last_vld_d   = last_vld_q;
    best_found_d = best_found_q;
    k_d          = k_q;
    slot_vld_d   = slot_vld_q;
    filled_d     = filled_q;
    i_d          = i_q;
    total_d      = total_q;
    out_vld_d    = out_vld_q;

    if (cmd_i.load && store_ok) begin
      cnt_d = cnt_q + gdjs_pkg::JobCw'(1);
      if (sat_dl > hz_q) begin
        hz_d = sat_dl;
      end
    end
    if (cmd_i.finish) begin
      cnt_d = '0;
      hz_d  = '0;
    end
    if (cmd_i.sched_init) begin
      slot_vld_d   = '0;
      last_vld_d   = 1'b0;
      filled_d     = '0;
      r_d          = '0;
      j_d          = '0;
      best_found_d = 1'b0;
    end
    if (cmd_i.scan_rd) begin
      j_d = j_q + gdjs_pkg::JobAw'(1);
    end
    if (cand_better) begin
      best_found_d = 1'b1;
    end
    if (cmd_i.place_init) begin
      k_d = (best_dl_q < hz_q) ? best_dl_q : hz_q;
    end
    if (cmd_i.place_step && (k_q != '0)) begin
      if (k_free) begin
        slot_vld_d[slot_addr] = 1'b1;
        filled_d              = filled_q + gdjs_pkg::SlotW'(1);
      end else begin
        k_d = k_q - gdjs_pkg::SlotW'(1);
      end
    end
    if (cmd_i.round_next) begin
      last_vld_d   = 1'b1;
      r_d          = r_q + gdjs_pkg::JobAw'(1);
      j_d          = '0;
      best_found_d = 1'b0;
    end
    if (cmd_i.out_init) begin
      i_d     = gdjs_pkg::SlotW'(1);
      total_d = '0;
    end
    if (cmd_i.out_ld) begin
      total_d   = total_q + gdjs_pkg::TotalW'(ld_profit);
      out_vld_d = 1'b1;
    end
    if (cmd_i.out_next) begin
      out_vld_d = 1'b0;
      i_d       = i_q + gdjs_pkg::SlotW'(1);
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q        <= '0;
      hz_q         <= '0;
      j_q          <= '0;
      r_q          <= '0;
      cmp_vld_q    <= 1'b0;
      cmp_idx_q    <= '0;
      last_vld_q   <= 1'b0;
      best_found_q <= 1'b0;
      k_q          <= '0;
      slot_vld_q   <= '0;
      filled_q     <= '0;
      i_q          <= '0;
      total_q      <= '0;
      out_vld_q    <= 1'b0;
    end else begin
      cnt_q        <= cnt_d;
      hz_q         <= hz_d;
      j_q          <= j_d;
      r_q          <= r_d;
      cmp_vld_q    <= cmd_i.scan_rd;
      cmp_idx_q    <= j_q;
      last_vld_q   <= last_vld_d;
      best_found_q <= best_found_d;
      k_q          <= k_d;
      slot_vld_q   <= slot_vld_d;
      filled_q     <= filled_d;
      i_q          <= i_d;
      total_q      <= total_d;
      out_vld_q    <= out_vld_d;
    end
  end

  // job memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && store_ok) begin
      mem[gdjs_pkg::JobAw'(cnt_q)] <= '{name:     in_data_i.job_name,
                                        deadline: sat_dl,
                                        profit:   in_data_i.job_profit};
    end
    rd_data_q <= mem[rd_addr];
  end

  // best candidate, previous pick and slot contents
  always_ff @(posedge clk_i) begin
    if (cand_better) begin
      best_idx_q    <= cmp_idx_q;
      best_profit_q <= rd_data_q.profit;
      best_dl_q     <= rd_data_q.deadline;
    end
    if (cmd_i.round_next) begin
      last_idx_q    <= best_idx_q;
      last_profit_q <= best_profit_q;
    end
    if (cmd_i.place_step && k_free) begin
      slot_idx_q[slot_addr] <= best_idx_q;
    end
    if (cmd_i.out_ld) begin
      out_q.slot_number   <= gdjs_pkg::SlotNumW'(i_q);
      out_q.slot_filled   <= slot_vld_q[slot_addr];
      out_q.placed_name   <= ld_name;
      out_q.placed_profit <= ld_profit;
      out_q.total_profit  <= total_q + gdjs_pkg::TotalW'(ld_profit);
      out_q.last_slot     <= (i_q == hz_q);
    end
  end

  // status
  assign sts_o.hz_zero     = (hz_q == '0);
  assign sts_o.scan_last   = (gdjs_pkg::JobCw'(j_q) + gdjs_pkg::JobCw'(1)) == cnt_q;
  assign sts_o.k_done      = (k_q == '0) || k_free;
  assign sts_o.rounds_last = (gdjs_pkg::JobCw'(r_q) + gdjs_pkg::JobCw'(1)) == cnt_q;
  assign sts_o.sched_full  = (filled_q == hz_q);
  assign sts_o.slot_last   = (i_q == hz_q);
  assign sts_o.out_taken   = out_vld_q && !out_stall_i;

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

// ===== hdl/gdjs_ctrl.sv =====
// ----------------------------------------------------------------------------
// gdjs_ctrl
// Controller: loads jobs, runs selection rounds with slot search, then walks
// the slots one result at a time.
// ----------------------------------------------------------------------------
module gdjs_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_last_i,
  output logic                in_stall_o,
  input  gdjs_pkg::gdjs_sts_t sts_i,
  output gdjs_pkg::gdjs_cmd_t cmd_o
);

  localparam logic [3:0] SIdle    = 4'd0;
  localparam logic [3:0] SStart   = 4'd1;
  localparam logic [3:0] SScan    = 4'd2;
  localparam logic [3:0] SDrain   = 4'd3;
  localparam logic [3:0] SPinit   = 4'd4;
  localparam logic [3:0] SPlace   = 4'd5;
  localparam logic [3:0] SNext    = 4'd6;
  localparam logic [3:0] SOutRd   = 4'd7;
  localparam logic [3:0] SOutLd   = 4'd8;
  localparam logic [3:0] SOutWait = 4'd9;

  logic [3:0] state_q, state_d;

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      SIdle: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (in_last_i) begin
            state_d = SStart;
          end
        end
      end
      SStart: begin
        cmd_o.sched_init = 1'b1;
        if (sts_i.hz_zero) begin
          cmd_o.finish = 1'b1;
          state_d      = SIdle;
        end else begin
          state_d = SScan;
        end
      end
      SScan: begin
        cmd_o.scan_rd = 1'b1;
        if (sts_i.scan_last) begin
          state_d = SDrain;
        end
      end
      SDrain: begin
        state_d = SPinit;
      end
      SPinit: begin
        cmd_o.place_init = 1'b1;
        state_d          = SPlace;
      end
      SPlace: begin
        cmd_o.place_step = 1'b1;
        if (sts_i.k_done) begin
          state_d = SNext;
        end
      end
      SNext: begin
        cmd_o.round_next = 1'b1;
        if (sts_i.rounds_last || sts_i.sched_full) begin
          cmd_o.out_init = 1'b1;
          state_d        = SOutRd;
        end else begin
          state_d = SScan;
        end
      end
      SOutRd: begin
        cmd_o.out_rd = 1'b1;
        state_d      = SOutLd;
      end
      SOutLd: begin
        cmd_o.out_ld = 1'b1;
        state_d      = SOutWait;
      end
      SOutWait: begin
        if (sts_i.out_taken) begin
          cmd_o.out_next = 1'b1;
          if (sts_i.slot_last) begin
            cmd_o.finish = 1'b1;
            state_d      = SIdle;
          end else begin
            state_d = SOutRd;
          end
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== hdl/greedy_deadline_job_scheduler_top.sv =====
// ----------------------------------------------------------------------------
// greedy_deadline_job_scheduler_top
// Collects jobs, picks them by profit (earliest first on ties), places each
// in the latest free slot at or before its deadline, and emits one result
// per slot with a running profit total.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+---------------------
//   in      | into      | in_valid_i / in_stall_o | gdjs_in_t  in_data_i
//   out     | out of    | out_valid_o/out_stall_i | gdjs_out_t out_data_o
//
// A job item is taken whenever one is offered while loading, so items can arrive back to back.
// The item with last_job set starts scheduling: n selection rounds over the
// job memory's single read port, each a full scan followed by a slot search,
// ending early once every slot up to the horizon is filled.
// Each slot result then goes through a read, a load and a wait until it is taken.
// Reset clears all control state at once; no clearing pass is needed.
// Input stays stalled from scheduling start until the last result is taken.
// ----------------------------------------------------------------------------
module greedy_deadline_job_scheduler_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  gdjs_pkg::gdjs_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output gdjs_pkg::gdjs_out_t out_data_o
);

  gdjs_pkg::gdjs_cmd_t cmd;
  gdjs_pkg::gdjs_sts_t sts;

  // sequencer
  gdjs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_last_i  (in_data_i.last_job),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // storage and arithmetic
  gdjs_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // no new job is taken while a result is pending
  a_out_blocks_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("job item taken while a result is pending");

  // slot numbers start at one
  a_slot_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.slot_number != '0))
    else $error("result with slot number zero");

  // empty slots carry no job
  a_empty_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.slot_filled) |->
      ((out_data_o.placed_profit == '0) && (out_data_o.placed_name == '0)))
    else $error("empty slot carries job data");

  // final slot taken ends the result stream
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && out_data_o.last_slot) |=> !out_valid_o)
    else $error("result after final slot");

endmodule

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Testbench for the greedy deadline job scheduler. Job sets are fed through
// a queue-driven input driver, and a clocked monitor checks every slot result
// against an in-bench schedule predictor. The predictor sorts jobs by profit
// with stable ties and fills the latest free slot at or before each deadline.
// A directed part covers the special cases. A random part follows, with one
// set that overfills the job store. Both sides insert random gaps.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // watchdog limit on cycles with no item moving, and the settle time at the end
  localparam int IdleLimit   = 20000;
  localparam int DrainCycles = 7000;

  typedef struct {
    logic [gdjs_pkg::NameW-1:0]   name;
    logic [gdjs_pkg::DlW-1:0]     deadline;
    logic [gdjs_pkg::ProfitW-1:0] profit;
  } job_t;

  // hold: wait for every predicted slot result before offering this item
  typedef struct {
    gdjs_pkg::gdjs_in_t job;
    bit                 hold;
  } job_req_t;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  gdjs_pkg::gdjs_in_t  in_data_i   = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  gdjs_pkg::gdjs_out_t out_data_o;

  job_req_t            job_queue[$];
  gdjs_pkg::gdjs_out_t slot_queue[$];
  job_t                job_store[gdjs_pkg::MaxJobs];
  int                  job_total = 0;
  int                  job_sent  = 0;
  int                  err_cnt   = 0;
  int                  quiet_cyc = 0;
  logic                calm;

  greedy_deadline_job_scheduler_top uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // no random gaps on either side while this window of items goes through
  assign calm = (job_sent >= 20) && (job_sent < 45);

  // build the schedule from the stored jobs and queue one result per slot
  task automatic build_slots();
    int   order[gdjs_pkg::MaxJobs];
    bit   used[gdjs_pkg::MaxSlots+1];
    int   owner[gdjs_pkg::MaxSlots+1];
    int   pos, k, hz, filled;
    bit   placed;
    logic [gdjs_pkg::TotalW-1:0] total;
    gdjs_pkg::gdjs_out_t r;
    // stable insertion sort, highest profit first
    for (int i = 0; i < job_total; i++) begin
      pos = i;
      while (pos > 0 && job_store[order[pos-1]].profit < job_store[i].profit) begin
        order[pos] = order[pos-1];
        pos--;
      end
      order[pos] = i;
    end
    hz = 0;
    for (int i = 0; i < job_total; i++)
      if (int'(job_store[i].deadline) > hz) hz = int'(job_store[i].deadline);
    for (int s = 0; s <= gdjs_pkg::MaxSlots; s++) begin
      used[s]  = 1'b0;
      owner[s] = 0;
    end
    // latest free slot at or before the deadline
    filled = 0;
    for (int i = 0; i < job_total && filled < hz; i++) begin
      k = int'(job_store[order[i]].deadline);
      if (k > hz) k = hz;
      placed = 1'b0;
      while (k >= 1 && !placed) begin
        if (!used[k]) begin
          used[k]  = 1'b1;
          owner[k] = order[i];
          filled++;
          placed = 1'b1;
        end else begin
          k--;
        end
      end
    end
    // empty slots add nothing to the running total
    total = '0;
    for (int s = 1; s <= hz; s++) begin
      r = '0;
      r.slot_number = gdjs_pkg::SlotNumW'(s);
      r.slot_filled = used[s];
      if (used[s]) begin
        r.placed_name   = job_store[owner[s]].name;
        r.placed_profit = job_store[owner[s]].profit;
      end
      total          = total + gdjs_pkg::TotalW'(r.placed_profit);
      r.total_profit = total;
      r.last_slot    = (s == hz);
      slot_queue.push_back(r);
    end
    job_total = 0;
  endtask

  // store one accepted job; a full store drops it, last_job still schedules
  task automatic take_job(input gdjs_pkg::gdjs_in_t it);
    if (job_total < gdjs_pkg::MaxJobs) begin
      job_store[job_total].name     = it.job_name;
      job_store[job_total].deadline =
        (int'(it.job_deadline) > gdjs_pkg::MaxSlots) ? gdjs_pkg::DlW'(gdjs_pkg::MaxSlots)
                                                     : it.job_deadline;
      job_store[job_total].profit   = it.job_profit;
      job_total++;
    end
    if (it.last_job) build_slots();
  endtask

  task automatic queue_job(input logic [gdjs_pkg::NameW-1:0] name,
                           input logic [gdjs_pkg::DlW-1:0] dl,
                           input logic [gdjs_pkg::ProfitW-1:0] profit, input bit last,
                           input bit hold);
    job_req_t q;
    q.job.job_name     = name;
    q.job.job_deadline = dl;
    q.job.job_profit   = profit;
    q.job.last_job     = last;
    q.hold             = hold;
    job_queue.push_back(q);
  endtask

  task automatic check_field(input string field, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      err_cnt++;
    end
  endtask

  // input driver
  always @(posedge clk_i or negedge rst_ni) begin : drive
    job_req_t nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        take_job(in_data_i);
        job_sent++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (job_queue.size() != 0 && (calm || $urandom_range(99) >= 25) &&
            !(job_queue[0].hold && slot_queue.size() != 0)) begin
          nxt = job_queue.pop_front();
          in_valid_i <= 1'b1;
          in_data_i  <= nxt.job;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i or negedge rst_ni) begin : observe
    gdjs_pkg::gdjs_out_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (slot_queue.size() == 0) begin
          $error("slot result for slot %0d with none predicted", out_data_o.slot_number);
          err_cnt++;
        end else begin
          want = slot_queue.pop_front();
          check_field("slot_number", int'(want.slot_number), int'(out_data_o.slot_number));
          check_field("slot_filled", int'(want.slot_filled), int'(out_data_o.slot_filled));
          check_field("placed_name", int'(want.placed_name), int'(out_data_o.placed_name));
          check_field("placed_profit", int'(want.placed_profit),
                      int'(out_data_o.placed_profit));
          check_field("total_profit", int'(want.total_profit),
                      int'(out_data_o.total_profit));
          check_field("last_slot", int'(want.last_slot), int'(out_data_o.last_slot));
        end
      end
      out_stall_i <= calm ? 1'b0 : ($urandom_range(99) < 25);
    end
  end

  // watchdog on cycles where no item moves on either side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
        quiet_cyc <= 0;
      else
        quiet_cyc <= quiet_cyc + 1;
      if (quiet_cyc >= IdleLimit) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    int set_len;
    int dl;
    int r;
    bit big_done;
    logic [gdjs_pkg::ProfitW-1:0] pf;

    // single job, name and profit at their top values, deadline one
    queue_job(16'hFFFF, 6'd1, 16'hFFFF, 1'b1, 1'b0);
    // only a zero deadline: empty horizon, no results
    queue_job(16'h0000, 6'd0, 16'h0000, 1'b1, 1'b1);
    // deadlines above the slot count saturate, full 32-slot horizon
    queue_job(16'h4142, 6'd63, 16'd100, 1'b0, 1'b1);
    queue_job(16'h4344, 6'd33, 16'd100, 1'b0, 1'b0);
    queue_job(16'h4546, 6'd32, 16'd0, 1'b1, 1'b0);
    // equal profits keep arrival order, one dropped, zero deadline, empty slot
    queue_job(16'h5051, 6'd2, 16'd500, 1'b0, 1'b1);
    queue_job(16'h5253, 6'd2, 16'd500, 1'b0, 1'b0);
    queue_job(16'h5455, 6'd2, 16'd500, 1'b0, 1'b0);
    queue_job(16'h5657, 6'd0, 16'd900, 1'b0, 1'b0);
    queue_job(16'h5859, 6'd4, 16'd10, 1'b1, 1'b0);
    // low profit arrives first and is pushed down to an earlier slot
    queue_job(16'h6162, 6'd3, 16'd1, 1'b0, 1'b0);
    queue_job(16'h6364, 6'd3, 16'hFFFF, 1'b0, 1'b0);
    queue_job(16'h6566, 6'd1, 16'd30000, 1'b1, 1'b0);

    // random sets, mostly short; one set overfills the job store
    big_done = 1'b0;
    while (job_queue.size() < 133) begin
      if (!big_done && job_queue.size() >= 50) begin
        set_len  = gdjs_pkg::MaxJobs + 2;
        big_done = 1'b1;
      end else begin
        set_len = $urandom_range(1, 8);
      end
      for (int j = 0; j < set_len; j++) begin
        r = $urandom_range(9);
        if (r == 0)      dl = 0;
        else if (r == 1) dl = $urandom_range(33, 63);
        else if (r < 7)  dl = $urandom_range(1, 8);
        else             dl = $urandom_range(1, 32);
        if ($urandom_range(1) == 0) pf = gdjs_pkg::ProfitW'($urandom_range(0, 7) * 1000);
        else                        pf = gdjs_pkg::ProfitW'($urandom);
        queue_job(gdjs_pkg::NameW'($urandom), gdjs_pkg::DlW'(dl), pf, j == set_len - 1,
                  j == 0 && $urandom_range(3) == 0);
      end
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (job_queue.size() != 0 || in_valid_i || slot_queue.size() != 0)
      @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (err_cnt == 0 && slot_queue.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
